/* rtl/core/btns_pkg.sv */
// Shared types, constants and helper functions for the box top-K / NMS selector.
// No dependencies; every btns_* module and the core import it.
`default_nettype none
package btns_pkg;

    localparam int RESULT_CAP = 16;

    localparam logic [1:0] REG_LOGIT_THR = 2'd0;
    localparam logic [1:0] REG_IOU_THR   = 2'd1;
    localparam logic [1:0] REG_INV_W     = 2'd2;
    localparam logic [1:0] REG_INV_H     = 2'd3;

    typedef struct packed {
        logic signed [15:0] logit;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [10:0]        anchor;
    } t_box;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } t_chain_ctl;

    function automatic logic [15:0] sig_tab(input logic [4:0] i);
        logic [15:0] v;
        unique case (i)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] logistic(input logic signed [15:0] x);
        logic [15:0] a;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [19:0] prod;
        logic [15:0] p;
        a = x[15] ? 16'(-{x[15], x}) : x;
        if (x == 16'sh8000) begin
            a = 16'hFFFF;
        end
        lo = sig_tab({1'b0, a[10:7]});
        hi = sig_tab(5'({1'b0, a[10:7]} + 5'd1));
        prod = 20'(hi - lo) * 20'(a[6:0]);
        if (a >= 16'd2048) begin
            p = 16'd65514;
        end else begin
            p = lo + 16'(prod >> 7);
        end
        return x[15] ? 16'(17'h10000 - 17'(p)) : p;
    endfunction

    // Q22 value -> rounded, floored Q2.14 with saturation
    function automatic logic signed [15:0] sat_q14(input logic signed [34:0] v);
        logic signed [34:0] t;
        t = (v + 35'sd128) >>> 8;
        if (t > 35'sd32767) begin
            return 16'sd32767;
        end else if (t < -35'sd32768) begin
            return -16'sd32768;
        end else begin
            return t[15:0];
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/box_topk_nms_select_core.sv */
// Box top-K selection with IoU suppression: decode, sorted cell chain, NMS sequencer.
// Takes one anchor beat per cycle while busy is low; chain insertion follows through stage A and stage B.
// After the last anchor: each candidate runs past every survivor through the overlap
// pipeline (skipped while none survive), then one result beat per cycle; busy is high to done.
// Reset (synchronous, active low) empties the chain and restores register defaults.
// Depends on btns_pkg, btns_kept_cell, btns_iou_unit.
`default_nettype none
module box_topk_nms_select_core #(
    parameter int MAX_KEPT     = 16,
    parameter int ANCHOR_LIMIT = 2048
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic signed [15:0] i_score_logit,
    input  wire logic [15:0]        i_anchor_x,
    input  wire logic [15:0]        i_anchor_y,
    input  wire logic signed [15:0] i_offset_x,
    input  wire logic signed [15:0] i_offset_y,
    input  wire logic signed [15:0] i_raw_width,
    input  wire logic signed [15:0] i_raw_height,
    input  wire logic               i_last_anchor,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [15:0]             o_probability,
    output logic signed [15:0]      o_center_x,
    output logic signed [15:0]      o_center_y,
    output logic signed [15:0]      o_box_w,
    output logic signed [15:0]      o_box_h,
    output logic [10:0]             o_source_anchor,
    output logic                    o_last_box
);
    import btns_pkg::*;

    localparam int CW  = $clog2(ANCHOR_LIMIT + 1);
    localparam int SCW = $clog2(RESULT_CAP + 1);
    localparam int SIW = $clog2(RESULT_CAP);

    typedef enum logic [2:0] {S_RUN, S_CAND, S_SCAN, S_WAIT, S_DEC, S_EMIT, S_DONE} t_state;

    logic signed [15:0] r_logit_thr;
    logic [15:0] r_iou_thr, r_inv_w, r_inv_h;
    logic [CW-1:0] r_cnt;
    logic accept;

    logic r_a_vld, r_a_last;
    logic signed [32:0] r_a_px, r_a_py, r_a_pw, r_a_ph;
    logic [15:0] r_a_ax, r_a_ay;
    logic signed [15:0] r_a_logit;
    logic [10:0] r_a_anchor;
    t_box n_b_box, r_b_box;
    logic r_b_vld, r_b_last;

    t_state r_state;
    logic r_busy;
    t_box r_cand;
    logic r_sup;
    logic [SCW-1:0] r_sc, r_idx;
    t_box r_surv [RESULT_CAP];

    t_chain_ctl ctl;
    t_box w_box [MAX_KEPT];
    logic [MAX_KEPT-1:0] w_vld, w_beat;
    logic iou_vld, iou_hit, iou_busy;
    logic [15:0] n_prob;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logit_thr <= 16'sd0;
            r_iou_thr   <= 16'd32768;
            r_inv_w     <= 16'd341;
            r_inv_h     <= 16'd341;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_LOGIT_THR: r_logit_thr <= i_cfg_wdata;
                REG_IOU_THR:   r_iou_thr   <= i_cfg_wdata;
                REG_INV_W:     r_inv_w     <= i_cfg_wdata;
                REG_INV_H:     r_inv_h     <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    // stage A: multiply by reciprocal input size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_a_vld  <= 1'b0;
            r_a_last <= 1'b0;
            r_b_vld  <= 1'b0;
            r_b_last <= 1'b0;
        end else begin
            r_a_vld  <= accept && (r_cnt < CW'(ANCHOR_LIMIT));
            r_a_last <= accept && i_last_anchor;
            if (accept) begin
                if (i_last_anchor) begin
                    r_cnt <= '0;
                end else if (r_cnt < CW'(ANCHOR_LIMIT)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            r_b_vld  <= r_a_vld && (r_a_logit >= r_logit_thr)
                        && (n_b_box.w > 16'sd0) && (n_b_box.h > 16'sd0);
            r_b_last <= r_a_last;
        end
        r_a_px     <= i_offset_x * $signed({1'b0, r_inv_w});
        r_a_py     <= i_offset_y * $signed({1'b0, r_inv_h});
        r_a_pw     <= i_raw_width * $signed({1'b0, r_inv_w});
        r_a_ph     <= i_raw_height * $signed({1'b0, r_inv_h});
        r_a_ax     <= i_anchor_x;
        r_a_ay     <= i_anchor_y;
        r_a_logit  <= i_score_logit;
        r_a_anchor <= 11'(r_cnt);
        r_b_box    <= n_b_box;
    end

    // stage B: add anchor, round and saturate
    always_comb begin
        n_b_box.logit  = r_a_logit;
        n_b_box.cx     = sat_q14($signed({13'd0, r_a_ax, 6'd0}) + 35'(r_a_px));
        n_b_box.cy     = sat_q14($signed({13'd0, r_a_ay, 6'd0}) + 35'(r_a_py));
        n_b_box.w      = sat_q14(35'(r_a_pw));
        n_b_box.h      = sat_q14(35'(r_a_ph));
        n_b_box.anchor = r_a_anchor;
    end

    always_comb begin
        ctl.ins = r_b_vld;
        ctl.pop = (r_state == S_CAND) && w_vld[0] && (r_sc < SCW'(RESULT_CAP));
        ctl.clr = (r_state == S_DONE);
    end

    for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
        btns_kept_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new        (r_b_box),
            .i_prev       (g == 0 ? r_b_box : w_box[(g + MAX_KEPT - 1) % MAX_KEPT]),
            .i_prev_valid (g == 0 ? 1'b0 : w_vld[(g + MAX_KEPT - 1) % MAX_KEPT]),
            .i_prev_beat  (g == 0 ? 1'b0 : w_beat[(g + MAX_KEPT - 1) % MAX_KEPT]),
            .i_next       (w_box[(g + 1) % MAX_KEPT]),
            .i_next_valid (g == MAX_KEPT - 1 ? 1'b0 : w_vld[(g + 1) % MAX_KEPT]),
            .o_box        (w_box[g]),
            .o_valid      (w_vld[g]),
            .o_beat       (w_beat[g])
        );
    end

    btns_iou_unit u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == S_SCAN),
        .i_a     (r_cand),
        .i_b     (r_surv[0]),
        .i_thr   (r_iou_thr),
        .o_valid (iou_vld),
        .o_hit   (iou_hit),
        .o_busy  (iou_busy)
    );

    assign n_prob = logistic(r_surv[0].logit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_busy  <= 1'b0;
            r_sc    <= '0;
            r_idx   <= '0;
            r_sup   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_EMIT);
            if (accept && i_last_anchor) begin
                r_busy <= 1'b1;
            end
            if (iou_vld && iou_hit) begin
                r_sup <= 1'b1;
            end
            unique case (r_state)
                S_RUN: begin
                    if (r_b_last) begin
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    if (w_vld[0] && (r_sc < SCW'(RESULT_CAP))) begin
                        r_cand  <= w_box[0];
                        r_sup   <= 1'b0;
                        r_idx   <= '0;
                        r_state <= (r_sc == '0) ? S_DEC : S_SCAN;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_SCAN: begin
                    // rotate the live survivors past the overlap unit
                    for (int k = 0; k < RESULT_CAP; k++) begin
                        if (SCW'(k) + 1'b1 == r_sc) begin
                            r_surv[k] <= r_surv[0];
                        end else if (k < RESULT_CAP - 1) begin
                            r_surv[k] <= r_surv[(k + 1) % RESULT_CAP];
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_sc) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!iou_busy) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (!r_sup) begin
                        r_surv[r_sc[SIW-1:0]] <= r_cand;
                        r_sc <= r_sc + 1'b1;
                    end
                    r_state <= S_CAND;
                end
                S_EMIT: begin
                    if (r_sc == '0) begin
                        o_found         <= 1'b0;
                        o_probability   <= '0;
                        o_center_x      <= '0;
                        o_center_y      <= '0;
                        o_box_w         <= '0;
                        o_box_h         <= '0;
                        o_source_anchor <= '0;
                        o_last_box      <= 1'b1;
                        r_state         <= S_DONE;
                    end else begin
                        o_found         <= 1'b1;
                        o_probability   <= n_prob;
                        o_center_x      <= r_surv[0].cx;
                        o_center_y      <= r_surv[0].cy;
                        o_box_w         <= r_surv[0].w;
                        o_box_h         <= r_surv[0].h;
                        o_source_anchor <= r_surv[0].anchor;
                        o_last_box      <= (r_sc == SCW'(1));
                        for (int k = 0; k < RESULT_CAP - 1; k++) begin
                            r_surv[k] <= r_surv[k + 1];
                        end
                        r_sc <= r_sc - 1'b1;
                        if (r_sc == SCW'(1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_busy  <= 1'b0;
                    r_sc    <= '0;
                    r_state <= S_RUN;
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

`ifndef SYNTH
    a_out_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result beat outside a busy frame");
    a_notfound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_last_box)
        else $error("not-found beat without last flag");
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_anchor) |=> o_busy)
        else $error("busy not raised after last anchor");
    a_sc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc <= SCW'(RESULT_CAP))
        else $error("survivor count overflow");
`endif
endmodule
`default_nettype wire

/* rtl/core/btns_kept_cell.sv */
// One cell of the sorted top-K chain: holds one box, inserts, shifts and pops.
// Depends on btns_pkg.
`default_nettype none
module btns_kept_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  btns_pkg::t_chain_ctl    i_ctl,
    input  btns_pkg::t_box          i_new,
    input  btns_pkg::t_box          i_prev,
    input  wire logic               i_prev_valid,
    input  wire logic               i_prev_beat,
    input  btns_pkg::t_box          i_next,
    input  wire logic               i_next_valid,
    output btns_pkg::t_box          o_box,
    output logic                    o_valid,
    output logic                    o_beat
);
    import btns_pkg::*;

    t_box r_box;
    logic r_valid;

    // new entry goes ahead of this one; equal logit loses (later anchor)
    assign o_beat  = !r_valid || (i_new.logit > r_box.logit);
    assign o_box   = r_box;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
            r_box   <= i_next;
        end else if (i_ctl.ins) begin
            if (i_prev_beat) begin
                r_box   <= i_prev;
                r_valid <= i_prev_valid;
            end else if (o_beat) begin
                r_box   <= i_new;
                r_valid <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/btns_iou_unit.sv */
// Pipelined overlap test of two boxes against the IoU threshold, four stages.
// Depends on btns_pkg.
`default_nettype none
module btns_iou_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  btns_pkg::t_box      i_a,
    input  btns_pkg::t_box      i_b,
    input  wire logic [15:0]    i_thr,
    output logic                o_valid,
    output logic                o_hit,
    output logic                o_busy
);
    import btns_pkg::*;

    logic signed [17:0] al, ar, at, ab, bl, br, bt, bb;
    logic signed [18:0] dw, dh;
    logic [3:0]  r_v;
    logic [17:0] r1_iw, r1_ih;
    logic [14:0] r1_wa, r1_ha, r1_wb, r1_hb;
    logic [35:0] r2_inter;
    logic [29:0] r2_aa, r2_ab;
    logic signed [37:0] n_uni;
    logic [35:0] r3_inter;
    logic [33:0] r3_uni;
    logic        r3_pos;
    logic [35:0] r4_inter;
    logic [49:0] r4_prod;
    logic        r4_pos;

    always_comb begin
        al = (18'(i_a.cx) <<< 1) - 18'(i_a.w);
        ar = (18'(i_a.cx) <<< 1) + 18'(i_a.w);
        at = (18'(i_a.cy) <<< 1) - 18'(i_a.h);
        ab = (18'(i_a.cy) <<< 1) + 18'(i_a.h);
        bl = (18'(i_b.cx) <<< 1) - 18'(i_b.w);
        br = (18'(i_b.cx) <<< 1) + 18'(i_b.w);
        bt = (18'(i_b.cy) <<< 1) - 18'(i_b.h);
        bb = (18'(i_b.cy) <<< 1) + 18'(i_b.h);
        dw = 19'(ar < br ? ar : br) - 19'(al > bl ? al : bl);
        dh = 19'(ab < bb ? ab : bb) - 19'(at > bt ? at : bt);
        n_uni = 38'({r2_aa, 2'b00}) + 38'({r2_ab, 2'b00}) - 38'(r2_inter);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
        // kept boxes always have positive size
        r1_iw    <= dw[18] ? 18'd0 : dw[17:0];
        r1_ih    <= dh[18] ? 18'd0 : dh[17:0];
        r1_wa    <= i_a.w[14:0];
        r1_ha    <= i_a.h[14:0];
        r1_wb    <= i_b.w[14:0];
        r1_hb    <= i_b.h[14:0];
        r2_inter <= 36'(r1_iw) * 36'(r1_ih);
        r2_aa    <= 30'(r1_wa) * 30'(r1_ha);
        r2_ab    <= 30'(r1_wb) * 30'(r1_hb);
        r3_inter <= r2_inter;
        r3_pos   <= n_uni > 38'sd0;
        r3_uni   <= n_uni[33:0];
        r4_inter <= r3_inter;
        r4_pos   <= r3_pos;
        r4_prod  <= 50'(i_thr) * 50'(r3_uni);
    end

    assign o_valid = r_v[3];
    assign o_hit   = r4_pos ? ({r4_inter, 16'd0} >= 52'(r4_prod)) : (i_thr == 16'd0);
    assign o_busy  = |r_v;
endmodule
`default_nettype wire

/* tb/box_topk_nms_select_checker.sv */
// Checker for box_topk_nms_select_core: watches the config, anchor and result ports,
// predicts the emitted boxes per frame and compares them field by field.
// Depends on btns_pkg for register indexes and the result cap.
module box_topk_nms_select_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic signed [15:0] i_score_logit,
    input  wire logic [15:0]        i_anchor_x,
    input  wire logic [15:0]        i_anchor_y,
    input  wire logic signed [15:0] i_offset_x,
    input  wire logic signed [15:0] i_offset_y,
    input  wire logic signed [15:0] i_raw_width,
    input  wire logic signed [15:0] i_raw_height,
    input  wire logic               i_last_anchor,
    input  wire logic               i_valid,
    input  wire logic               i_found,
    input  wire logic [15:0]        i_probability,
    input  wire logic signed [15:0] i_center_x,
    input  wire logic signed [15:0] i_center_y,
    input  wire logic signed [15:0] i_box_w,
    input  wire logic signed [15:0] i_box_h,
    input  wire logic [10:0]        i_source_anchor,
    input  wire logic               i_last_box,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_frames,
    output int                      o_results,
    output int                      o_found_boxes
);
    timeunit 1ns;
    timeprecision 1ps;

    import btns_pkg::*;

    localparam int KEEP_MAX     = 16;
    localparam int ANCHOR_MAX   = 2048;

    typedef struct {
        int logit;
        int cx;
        int cy;
        int w;
        int h;
        int anchor;
    } t_cand;

    typedef struct {
        logic        found;
        logic [15:0] prob;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic [10:0] anchor;
        logic        last;
    } t_det;

    const int unsigned prob_tab[17] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };

    int          thr_logit;
    longint      thr_iou;
    longint      inv_w;
    longint      inv_h;
    t_cand       kept[$];
    int          anchor_idx;
    t_det        expected_dets[$];

    assign o_pending = expected_dets.size();

    function automatic int round_q14(longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return int'(r);
    endfunction

    function automatic int unsigned prob_of(int x);
        int unsigned a;
        int unsigned p;
        a = (x < 0) ? -x : x;
        if (a >= 2048) begin
            p = prob_tab[16];
        end else begin
            p = prob_tab[a >> 7]
                + (((prob_tab[(a >> 7) + 1] - prob_tab[a >> 7]) * (a & 127)) >> 7);
        end
        return (x < 0) ? 65536 - p : p;
    endfunction

    function automatic bit beats(t_cand a, t_cand b);
        if (a.logit != b.logit) return a.logit > b.logit;
        return a.anchor < b.anchor;
    endfunction

    function automatic bit too_close(t_cand a, t_cand b);
        longint al, ar, at, ab, bl, br, bt, bb, iw, ih, inter, uni;
        al = 2 * longint'(a.cx) - a.w;
        ar = 2 * longint'(a.cx) + a.w;
        at = 2 * longint'(a.cy) - a.h;
        ab = 2 * longint'(a.cy) + a.h;
        bl = 2 * longint'(b.cx) - b.w;
        br = 2 * longint'(b.cx) + b.w;
        bt = 2 * longint'(b.cy) - b.h;
        bb = 2 * longint'(b.cy) + b.h;
        iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
        ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni = 4 * longint'(a.w > 0 ? a.w : 0) * longint'(a.h > 0 ? a.h : 0)
            + 4 * longint'(b.w > 0 ? b.w : 0) * longint'(b.h > 0 ? b.h : 0) - inter;
        if (uni <= 0) return thr_iou == 0;
        return inter * 65536 >= thr_iou * uni;
    endfunction

    task automatic keep_candidate(t_cand c);
        int weakest;
        weakest = 0;
        if (kept.size() < KEEP_MAX) begin
            kept.push_back(c);
        end else begin
            for (int i = 1; i < KEEP_MAX; i++) begin
                if (beats(kept[weakest], kept[i])) weakest = i;
            end
            if (c.logit > kept[weakest].logit) kept[weakest] = c;
        end
    endtask

    task automatic close_frame();
        t_cand sorted[$];
        t_cand surv[$];
        t_cand t;
        t_det  d;
        bit    sup;
        int    j;
        sorted = kept;
        for (int i = 1; i < sorted.size(); i++) begin
            t = sorted[i];
            j = i;
            while (j > 0 && beats(t, sorted[j - 1])) begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = t;
        end
        foreach (sorted[i]) begin
            if (surv.size() < RESULT_CAP) begin
                sup = 0;
                foreach (surv[k]) begin
                    if (!sup && too_close(sorted[i], surv[k])) sup = 1;
                end
                if (!sup) surv.push_back(sorted[i]);
            end
        end
        if (surv.size() == 0) begin
            d = '{found: 1'b0, prob: '0, cx: '0, cy: '0, w: '0, h: '0,
                  anchor: '0, last: 1'b1};
            expected_dets.push_back(d);
        end
        foreach (surv[i]) begin
            d.found  = 1'b1;
            d.prob   = 16'(prob_of(surv[i].logit));
            d.cx     = 16'(surv[i].cx);
            d.cy     = 16'(surv[i].cy);
            d.w      = 16'(surv[i].w);
            d.h      = 16'(surv[i].h);
            d.anchor = 11'(surv[i].anchor);
            d.last   = (i == surv.size() - 1);
            expected_dets.push_back(d);
            o_found_boxes++;
        end
        kept.delete();
        anchor_idx = 0;
        o_frames++;
    endtask

    always @(posedge i_clk) begin
        t_cand c;
        t_det  e;
        if (!i_rst_n) begin
            thr_logit  = 0;
            thr_iou    = 32768;
            inv_w      = 341;
            inv_h      = 341;
            kept.delete();
            anchor_idx = 0;
            expected_dets.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_LOGIT_THR: thr_logit = int'($signed(i_cfg_wdata));
                    REG_IOU_THR:   thr_iou   = i_cfg_wdata;
                    REG_INV_W:     inv_w     = i_cfg_wdata;
                    REG_INV_H:     inv_h     = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_valid) begin
                o_results++;
                if (expected_dets.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("%0t: result beat with nothing expected", $realtime);
                end else begin
                    e = expected_dets.pop_front();
                    if (e.found !== i_found || e.prob !== i_probability
                        || e.cx !== i_center_x || e.cy !== i_center_y
                        || e.w !== i_box_w || e.h !== i_box_h
                        || e.anchor !== i_source_anchor || e.last !== i_last_box) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: mismatch exp f=%0d p=%0d c=(%0d,%0d) s=(%0d,%0d) a=%0d l=%0d",
                                     $realtime, e.found, e.prob, $signed(e.cx), $signed(e.cy),
                                     $signed(e.w), $signed(e.h), e.anchor, e.last);
                            $display("%0t:          got f=%0d p=%0d c=(%0d,%0d) s=(%0d,%0d) a=%0d l=%0d",
                                     $realtime, i_found, i_probability, i_center_x, i_center_y,
                                     i_box_w, i_box_h, i_source_anchor, i_last_box);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (anchor_idx < ANCHOR_MAX) begin
                    c.anchor = anchor_idx;
                    anchor_idx++;
                    c.logit = int'(i_score_logit);
                    c.cx = round_q14((longint'(i_anchor_x) << 6) + longint'(i_offset_x) * inv_w);
                    c.cy = round_q14((longint'(i_anchor_y) << 6) + longint'(i_offset_y) * inv_h);
                    c.w  = round_q14(longint'(i_raw_width) * inv_w);
                    c.h  = round_q14(longint'(i_raw_height) * inv_h);
                    if (c.logit >= thr_logit && c.w > 0 && c.h > 0) keep_candidate(c);
                end
                if (i_last_anchor) close_frame();
            end
        end
    end

    initial begin
        o_errors      = 0;
        o_frames      = 0;
        o_results     = 0;
        o_found_boxes = 0;
    end
endmodule

/* tb/testbench.sv */
// Top of the box_topk_nms_select_core testbench: clock, reset, config phases and anchor
// stimulus with random gaps. Depends on btns_pkg, the core and box_topk_nms_select_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import btns_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_addr = '0;
    logic [15:0]        i_cfg_wdata = '0;
    logic signed [15:0] i_score_logit = '0;
    logic [15:0]        i_anchor_x = '0;
    logic [15:0]        i_anchor_y = '0;
    logic signed [15:0] i_offset_x = '0;
    logic signed [15:0] i_offset_y = '0;
    logic signed [15:0] i_raw_width = '0;
    logic signed [15:0] i_raw_height = '0;
    logic               i_last_anchor = 1'b0;
    logic               o_valid;
    logic               o_found;
    logic [15:0]        o_probability;
    logic signed [15:0] o_center_x;
    logic signed [15:0] o_center_y;
    logic signed [15:0] o_box_w;
    logic signed [15:0] o_box_h;
    logic [10:0]        o_source_anchor;
    logic               o_last_box;

    int  errors, pending, frames, results, found_boxes;
    int  anchors_sent;
    bit  gaps_on;
    int  settle;

    always #6 i_clk = ~i_clk;

    box_topk_nms_select_core DUT (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_score_logit, .i_anchor_x, .i_anchor_y, .i_offset_x, .i_offset_y,
        .i_raw_width, .i_raw_height, .i_last_anchor, .o_valid, .o_found, .o_probability,
        .o_center_x, .o_center_y, .o_box_w, .o_box_h, .o_source_anchor, .o_last_box
    );

    box_topk_nms_select_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_score_logit, .i_anchor_x, .i_anchor_y, .i_offset_x, .i_offset_y,
        .i_raw_width, .i_raw_height, .i_last_anchor, .i_valid(o_valid), .i_found(o_found),
        .i_probability(o_probability), .i_center_x(o_center_x), .i_center_y(o_center_y),
        .i_box_w(o_box_w), .i_box_h(o_box_h), .i_source_anchor(o_source_anchor),
        .i_last_box(o_last_box), .o_errors(errors), .o_pending(pending), .o_frames(frames),
        .o_results(results), .o_found_boxes(found_boxes)
    );

    // one anchor beat; called and returns at a rising edge
    task automatic send_anchor(int logit, int ax, int ay, int ox, int oy,
                               int rw, int rh, bit last);
        i_start       <= 1'b1;
        i_score_logit <= 16'(logit);
        i_anchor_x    <= 16'(ax);
        i_anchor_y    <= 16'(ay);
        i_offset_x    <= 16'(ox);
        i_offset_y    <= 16'(oy);
        i_raw_width   <= 16'(rw);
        i_raw_height  <= 16'(rh);
        i_last_anchor <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        anchors_sent++;
        if (gaps_on && $urandom_range(99) < 34) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(int thr, int iou, int invw, int invh);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_LOGIT_THR;
        i_cfg_wdata <= 16'(thr);
        @(posedge i_clk);
        i_cfg_addr  <= REG_IOU_THR;
        i_cfg_wdata <= 16'(iou);
        @(posedge i_clk);
        i_cfg_addr  <= REG_INV_W;
        i_cfg_wdata <= 16'(invw);
        @(posedge i_clk);
        i_cfg_addr  <= REG_INV_H;
        i_cfg_wdata <= 16'(invh);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_frame(int len, int hi_logit);
        int cx0, cy0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 20) begin
                send_anchor($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, i == len - 1);
            end else begin
                cx0 = 16384 * $urandom_range(1, 3);
                cy0 = 16384 * $urandom_range(1, 3);
                send_anchor(hi_logit ? $urandom_range(0, 4000) - 1000
                                     : $urandom_range(0, 65535) - 32768,
                            cx0 + $urandom_range(0, 600), cy0 + $urandom_range(0, 600),
                            $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                            $urandom_range(0, 4200) - 200, $urandom_range(0, 4200) - 200,
                            i == len - 1);
            end
        end
    endtask

    initial begin
        anchors_sent = 0;
        gaps_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty frame, extremes, threshold edge, zero/negative size, ties, overlap
        send_anchor(-1, 0, 0, 0, 0, 640, 640, 1'b1);
        drain();
        send_anchor(32767, 65535, 0, 32767, -32768, 32767, 32767, 1'b0);
        send_anchor(-32768, 32768, 32768, 0, 0, 640, 640, 1'b0);
        send_anchor(0, 32768, 32768, 0, 0, 0, 640, 1'b0);
        send_anchor(0, 32768, 32768, 0, 0, 640, -640, 1'b0);
        send_anchor(300, 16384, 16384, 0, 0, 1280, 1280, 1'b0);
        send_anchor(300, 16384, 16384, 64, 64, 1280, 1280, 1'b0);
        send_anchor(300, 49152, 49152, 0, 0, 1280, 1280, 1'b1);
        drain();
        for (int i = 0; i < 18; i++) begin
            send_anchor(i * 97 + 5, 3000 * i + 2000, 60000 - 3000 * i, 0, 0, 600, 600,
                        i == 17);
        end
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_cfg(0, 32768, 341, 341);
                1: write_cfg(-32768, 0, 1, 65535);
                2: write_cfg(32767, 65535, 65535, 1);
                3: write_cfg(-256, 16384, 1024, 2048);
                default: write_cfg($urandom_range(0, 3000) - 2000, $urandom,
                                   $urandom_range(1, 65535), $urandom_range(1, 65535));
            endcase
            gaps_on = (ph != 3);
            for (int n = 0; n < 36; ) begin
                settle = $urandom_range(1, 30);
                random_frame(settle, $urandom_range(99) < 70);
                n += settle;
            end
            drain();
        end
        write_cfg(0, 32768, 341, 341);

        $display("Covered %0d anchor beats over %0d frames, 7 register settings.",
                 anchors_sent, frames);
        $display("Checked %0d result beats, %0d carrying a box.", results, found_boxes);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout");
        $display("Verification failed");
        $finish;
    end
endmodule
